/* rtl/zph_pkg.sv */
package zph_pkg;

   localparam int BOARD_POINTS  = 361;
   localparam int HISTORY_DEPTH = 6;
   localparam int TABLE_DEPTH   = 2 * BOARD_POINTS;

   localparam int KEY_W   = 64;
   localparam int POINT_W = 9;
   localparam int REQ_W   = 3;
   localparam int ADDR_W  = $clog2(TABLE_DEPTH);
   localparam int SLOT_W  = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam int CSR_INDEX_W = 1;

   localparam logic [REQ_W-1:0] REQ_LOAD   = 3'd0;
   localparam logic [REQ_W-1:0] REQ_MOVE   = 3'd1;
   localparam logic [REQ_W-1:0] REQ_TOGGLE = 3'd2;
   localparam logic [REQ_W-1:0] REQ_RECORD = 3'd3;
   localparam logic [REQ_W-1:0] REQ_CHECK  = 3'd4;
   localparam logic [REQ_W-1:0] REQ_RESET  = 3'd5;
   localparam logic [REQ_W-1:0] REQ_SET    = 3'd6;
   localparam logic [REQ_W-1:0] REQ_REPLAY = 3'd7;

   localparam logic [CSR_INDEX_W-1:0] CSR_SIDE_KEY    = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SIDE_ENABLE = 1'd1;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [KEY_W-1:0]  wr_data;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
   } tbl_cmd_type;

endpackage

/* rtl/zph_if.sv */
interface zph_req_if import zph_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [REQ_W-1:0]   req_type;
   logic [POINT_W-1:0] point;
   logic               color;
   logic [KEY_W-1:0]   key_value;
   logic               first;
   logic               last;

   modport source (output valid, req_type, point, color, key_value, first, last,
                   input ready);
   modport sink (input valid, req_type, point, color, key_value, first, last,
                 output ready);
endinterface

interface zph_rsp_if import zph_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [KEY_W-1:0] current_key;
   logic             history_hit;

   modport source (output valid, current_key, history_hit, input ready);
   modport sink (input valid, current_key, history_hit, output ready);
endinterface

interface zph_csr_if import zph_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [KEY_W-1:0]       data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

/* rtl/zph_table_ram.sv */
module zph_table_ram import zph_pkg::*; (
   input  logic             clock,
   input  tbl_cmd_type      cmd,
   output logic [KEY_W-1:0] rd_data_ff
);

   logic [KEY_W-1:0] mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[cmd.wr_addr] <= cmd.wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[cmd.rd_addr];
      end
   end

endmodule

/* rtl/zobrist_position_hash_core.sv */
// After its request is accepted, a response passes through the stage-1 register and then the output register.
// Throughput: one transaction per cycle while responses are taken; each on-board move or replay reads the
//   table RAM once at acceptance and folds the word into the key register as stage 1 advances.
// Synchronous active-high reset clears the key, history, slot, replay parity,
//   configuration and pipeline valids; the table RAM is not cleared.
module zobrist_position_hash_core import zph_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   zph_req_if.sink   req_chan,
   zph_rsp_if.source rsp_chan,
   zph_csr_if.sink   csr_chan
);

   logic [KEY_W-1:0]  side_key_ff;
   logic              side_en_ff;
   logic              parity_ff, parity_in;

   logic              acc;
   logic              pt_ok;
   logic              fold_col;
   logic [ADDR_W-1:0] pt_idx;
   logic [ADDR_W-1:0] tbl_addr;
   tbl_cmd_type       tbl_cmd;
   logic [KEY_W-1:0]  rd_data;

   logic              s1_vld_ff;
   logic [REQ_W-1:0]  s1_type_ff;
   logic              s1_fold_ff;
   logic [KEY_W-1:0]  s1_kv_ff;
   logic              s1_first_ff;
   logic              s1_side_ff;
   logic              s1_adv;

   logic [KEY_W-1:0]  key_ff, key_in;
   logic [KEY_W-1:0]  hist_ff [HISTORY_DEPTH];
   logic [KEY_W-1:0]  hist_in [HISTORY_DEPTH];
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              hit;
   logic [KEY_W-1:0]  fold_word;

   logic              out_vld_ff;
   logic [KEY_W-1:0]  out_key_ff;
   logic              out_hit_ff;

   assign acc      = req_chan.valid && req_chan.ready;
   assign pt_ok    = (req_chan.point != '0) && (int'(req_chan.point) <= BOARD_POINTS);
   assign fold_col = (req_chan.req_type == REQ_REPLAY) ?
                     (!req_chan.first && parity_ff) : req_chan.color;
   assign pt_idx   = ADDR_W'(req_chan.point) - ADDR_W'(1);
   assign tbl_addr = fold_col ? (pt_idx + ADDR_W'(BOARD_POINTS)) : pt_idx;

   always_comb begin
      tbl_cmd.wr_en   = acc && (req_chan.req_type == REQ_LOAD) && pt_ok;
      tbl_cmd.wr_addr = tbl_addr;
      tbl_cmd.wr_data = req_chan.key_value;
      tbl_cmd.rd_en   = acc && pt_ok &&
                        ((req_chan.req_type == REQ_MOVE) || (req_chan.req_type == REQ_REPLAY));
      tbl_cmd.rd_addr = tbl_addr;
   end

   zph_table_ram u_table (
      .clock      (clock),
      .cmd        (tbl_cmd),
      .rd_data_ff (rd_data)
   );

   // replay parity follows the request stream, so it is tracked at acceptance
   always_comb begin
      parity_in = parity_ff;
      if (acc) begin
         case (req_chan.req_type)
            REQ_RESET: begin
               parity_in = 1'b0;
            end
            REQ_REPLAY: begin
               parity_in = !fold_col;
            end
            default: begin
               parity_in = parity_ff;
            end
         endcase
      end
   end

   assign s1_adv         = s1_vld_ff && (!out_vld_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_vld_ff || s1_adv;
   assign csr_chan.ready = 1'b1;

   assign fold_word = s1_fold_ff ? rd_data : '0;

   always_comb begin
      key_in  = key_ff;
      slot_in = slot_ff;
      hit     = 1'b0;
      for (int i = 0; i < HISTORY_DEPTH; i++) begin
         hist_in[i] = hist_ff[i];
      end
      case (s1_type_ff)
         REQ_MOVE: begin
            key_in = key_ff ^ fold_word;
         end
         REQ_TOGGLE: begin
            if (side_en_ff) begin
               key_in = key_ff ^ side_key_ff;
            end
         end
         REQ_RECORD: begin
            hist_in[slot_ff] = key_ff;
            slot_in = (slot_ff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + SLOT_W'(1);
         end
         REQ_CHECK: begin
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
               if (hist_ff[i] == s1_kv_ff) begin
                  hit = 1'b1;
               end
            end
         end
         REQ_RESET: begin
            key_in  = '0;
            slot_in = '0;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
               hist_in[i] = '0;
            end
         end
         REQ_SET: begin
            key_in = s1_kv_ff;
         end
         REQ_REPLAY: begin
            key_in = (s1_first_ff ? '0 : key_ff) ^ fold_word ^
                     (s1_side_ff ? side_key_ff : '0);
            if (s1_first_ff) begin
               slot_in = '0;
               for (int i = 0; i < HISTORY_DEPTH; i++) begin
                  hist_in[i] = '0;
               end
            end
         end
         default: begin
            key_in = key_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_key_ff <= '0;
         side_en_ff  <= 1'b0;
         parity_ff   <= 1'b0;
         s1_vld_ff   <= 1'b0;
         out_vld_ff  <= 1'b0;
         key_ff      <= '0;
         slot_ff     <= '0;
         for (int i = 0; i < HISTORY_DEPTH; i++) begin
            hist_ff[i] <= '0;
         end
      end else begin
         if (csr_chan.valid) begin
            if (csr_chan.index == CSR_SIDE_KEY) begin
               side_key_ff <= csr_chan.data;
            end
            if (csr_chan.index == CSR_SIDE_ENABLE) begin
               side_en_ff <= csr_chan.data[0];
            end
         end
         parity_ff <= parity_in;
         if (acc) begin
            s1_vld_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_vld_ff <= 1'b0;
         end
         if (s1_adv) begin
            out_vld_ff <= 1'b1;
            key_ff     <= key_in;
            slot_ff    <= slot_in;
            for (int i = 0; i < HISTORY_DEPTH; i++) begin
               hist_ff[i] <= hist_in[i];
            end
         end else if (rsp_chan.ready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_type_ff  <= req_chan.req_type;
         s1_fold_ff  <= pt_ok;
         s1_kv_ff    <= req_chan.key_value;
         s1_first_ff <= req_chan.first;
         s1_side_ff  <= req_chan.last && parity_in;
      end
      if (s1_adv) begin
         out_key_ff <= key_in;
         out_hit_ff <= (s1_type_ff == REQ_CHECK) && hit;
      end
   end

   assign rsp_chan.valid       = out_vld_ff;
   assign rsp_chan.current_key = out_key_ff;
   assign rsp_chan.history_hit = out_hit_ff;

endmodule

/* rtl/zph_checker.sv */
module zph_checker import zph_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic [REQ_W-1:0]   req_type,
   input logic [KEY_W-1:0]   req_key_value,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [KEY_W-1:0]   rsp_current_key,
   input logic               rsp_history_hit
);

   logic req_acc;
   assign req_acc = req_valid && req_ready;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_current_key) && $stable(rsp_history_hit))
      else $error("response payload changed while stalled");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_type == REQ_RESET)) ##1 rsp_ready |=>
         rsp_valid && (rsp_current_key == '0))
      else $error("key not cleared by reset transaction");

   assert property (@(posedge clock) disable iff (reset)
      (req_acc && (req_type == REQ_SET)) ##1 rsp_ready |=>
         rsp_valid && (rsp_current_key == $past(req_key_value, 2)))
      else $error("set key transaction not reflected");

endmodule

bind zobrist_position_hash_core zph_checker u_zph_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .req_type        (req_chan.req_type),
   .req_key_value   (req_chan.key_value),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_current_key (rsp_chan.current_key),
   .rsp_history_hit (rsp_chan.history_hit)
);

/* test/tb_zobrist_position_hash_core.sv */
`timescale 1ns / 100ps

module tb_zobrist_position_hash_core import zph_pkg::*; ();

   localparam int CYCLE_LIMIT = 200000;
   localparam int PHASE_ITEMS = 90;
   localparam int NUM_PHASES  = 5;
   localparam int POINT_MAX   = (1 << POINT_W) - 1;

   typedef struct packed {
      logic [REQ_W-1:0]   req_type;
      logic [POINT_W-1:0] point;
      logic               color;
      logic [KEY_W-1:0]   key_value;
      logic               first;
      logic               last;
   } hash_req_type;

   typedef struct packed {
      logic [KEY_W-1:0] key;
      logic             hit;
   } hash_result_type;

   class zobrist_scoreboard_type;
      logic [KEY_W-1:0] words [2][BOARD_POINTS];
      bit               written [2][BOARD_POINTS];
      int unsigned      loaded_pts [2][$];
      logic [KEY_W-1:0] pos_key;
      logic [KEY_W-1:0] hist [HISTORY_DEPTH];
      int unsigned      slot;
      bit               parity;
      logic [KEY_W-1:0] side_word;
      bit               side_en;
      hash_result_type  expected_q [$];
      int unsigned      errors;

      function new();
         side_word = '0;
         side_en   = 1'b0;
         errors    = 0;
         clear_position();
      endfunction

      function void clear_position();
         pos_key = '0;
         foreach (hist[i]) hist[i] = '0;
         slot   = 0;
         parity = 1'b0;
      endfunction

      function bit on_board(logic [POINT_W-1:0] pt);
         return pt >= 1 && pt <= BOARD_POINTS;
      endfunction

      function void fold_move(logic [POINT_W-1:0] pt, bit col);
         if (on_board(pt)) pos_key ^= words[col][pt-1];
      endfunction

      function void write_config(logic [CSR_INDEX_W-1:0] idx, logic [KEY_W-1:0] data);
         if (idx == CSR_SIDE_KEY) side_word = data;
         else if (idx == CSR_SIDE_ENABLE) side_en = data[0];
      endfunction

      function void note_request(hash_req_type r);
         hash_result_type res;
         res.hit = 1'b0;
         case (r.req_type)
            REQ_LOAD: begin
               if (on_board(r.point)) begin
                  words[r.color][r.point-1] = r.key_value;
                  if (!written[r.color][r.point-1]) begin
                     written[r.color][r.point-1] = 1'b1;
                     loaded_pts[r.color].push_back(32'(r.point));
                  end
               end
            end
            REQ_MOVE:   fold_move(r.point, r.color);
            REQ_TOGGLE: if (side_en) pos_key ^= side_word;
            REQ_RECORD: begin
               hist[slot] = pos_key;
               slot = (slot + 1) % HISTORY_DEPTH;
            end
            REQ_CHECK: begin
               foreach (hist[i]) if (hist[i] == r.key_value) res.hit = 1'b1;
            end
            REQ_RESET:  clear_position();
            REQ_SET:    pos_key = r.key_value;
            REQ_REPLAY: begin
               if (r.first) clear_position();
               fold_move(r.point, parity);
               parity ^= 1'b1;
               if (r.last && parity) pos_key ^= side_word;
            end
            default: ;
         endcase
         res.key = pos_key;
         expected_q.push_back(res);
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      task report(string msg);
         $display("mismatch @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(logic [KEY_W-1:0] key, logic hit);
         hash_result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected transaction key %h hit %b", key, hit));
         end else begin
            want = expected_q.pop_front();
            if (key !== want.key)
               report($sformatf("current_key got %h want %h", key, want.key));
            if (hit !== want.hit)
               report($sformatf("history_hit got %b want %b", hit, want.hit));
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   bit          quiet = 1'b0;
   int unsigned cycle_count = 0;
   int unsigned sent_items = 0;
   zobrist_scoreboard_type sb;

   zph_req_if req_bus();
   zph_rsp_if rsp_bus();
   zph_csr_if csr_bus();

   zobrist_position_hash_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready = quiet || ($urandom_range(99) >= 14);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready)
         sb.check_result(rsp_bus.current_key, rsp_bus.history_hit);
   end

   function automatic logic [KEY_W-1:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   function automatic hash_req_type req_of(logic [REQ_W-1:0] kind, int unsigned pt, bit col,
                                           logic [KEY_W-1:0] kv, bit first = 0, bit last = 0);
      hash_req_type r;
      r.req_type  = kind;
      r.point     = POINT_W'(pt);
      r.color     = col;
      r.key_value = kv;
      r.first     = first;
      r.last      = last;
      return r;
   endfunction

   // only points whose word for this color has been loaded, plus pass and off-board
   function automatic int unsigned pick_point(bit col);
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 8) return 0;
      if (roll < 16) return $urandom_range(POINT_MAX, BOARD_POINTS + 1);
      return sb.loaded_pts[col][$urandom_range(sb.loaded_pts[col].size() - 1)];
   endfunction

   task send_request(hash_req_type r);
      if (!quiet && $urandom_range(99) < 14) begin
         repeat ($urandom_range(1, 3)) begin
            @(negedge clock);
            req_bus.valid = 1'b0;
         end
      end
      @(negedge clock);
      req_bus.valid     = 1'b1;
      req_bus.req_type  = r.req_type;
      req_bus.point     = r.point;
      req_bus.color     = r.color;
      req_bus.key_value = r.key_value;
      req_bus.first     = r.first;
      req_bus.last      = r.last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(r);
      sent_items++;
   endtask

   task write_csr(logic [CSR_INDEX_W-1:0] idx, logic [KEY_W-1:0] data);
      @(negedge clock);
      csr_bus.valid = 1'b1;
      csr_bus.index = idx;
      csr_bus.data  = data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      sb.write_config(idx, data);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task drain();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task send_random_item();
      int unsigned roll;
      int unsigned pt;
      bit          col;
      logic [KEY_W-1:0] kv;
      roll = $urandom_range(99);
      col  = 1'($urandom_range(1));
      kv   = rand_word();
      if (roll < 17) begin
         case ($urandom_range(9))
            0:       pt = 0;
            1:       pt = $urandom_range(POINT_MAX, BOARD_POINTS + 1);
            default: pt = $urandom_range(BOARD_POINTS, 1);
         endcase
         send_request(req_of(REQ_LOAD, pt, col, kv));
      end else if (roll < 50) begin
         send_request(req_of(REQ_MOVE, pick_point(col), col, kv));
      end else if (roll < 60) begin
         send_request(req_of(REQ_TOGGLE, $urandom_range(POINT_MAX), col, kv));
      end else if (roll < 74) begin
         send_request(req_of(REQ_RECORD, $urandom_range(POINT_MAX), col, kv));
      end else if (roll < 88) begin
         case ($urandom_range(3))
            0, 1: kv = sb.hist[$urandom_range(HISTORY_DEPTH - 1)];
            2:    kv = sb.pos_key;
            default: ;
         endcase
         send_request(req_of(REQ_CHECK, $urandom_range(POINT_MAX), col, kv));
      end else if (roll < 92) begin
         send_request(req_of(REQ_RESET, $urandom_range(POINT_MAX), col, kv,
                             1'($urandom_range(1)), 1'($urandom_range(1))));
      end else begin
         case ($urandom_range(4))
            0:       kv = '0;
            1:       kv = '1;
            default: ;
         endcase
         send_request(req_of(REQ_SET, $urandom_range(POINT_MAX), col, kv));
      end
   endtask

   // one replay sequence, usually opened by first and closed by last
   task send_replay_run();
      int unsigned len;
      bit          with_first;
      bit          with_last;
      bit          first;
      bit          last;
      bit          col;
      len        = $urandom_range(1, 8);
      with_first = $urandom_range(99) < 90;
      with_last  = $urandom_range(99) < 85;
      for (int i = 0; i < len; i++) begin
         first = (i == 0 && with_first) || ($urandom_range(99) < 3);
         last  = (i == len - 1 && with_last) || ($urandom_range(99) < 3);
         col   = first ? 1'b0 : sb.parity;
         send_request(req_of(REQ_REPLAY, pick_point(col), 1'($urandom_range(1)), rand_word(),
                             first, last));
      end
   endtask

   initial begin
      bit          paused;
      int unsigned target;
      sb = new();
      req_bus.valid     = 1'b0;
      req_bus.req_type  = REQ_LOAD;
      req_bus.point     = '0;
      req_bus.color     = 1'b0;
      req_bus.key_value = '0;
      req_bus.first     = 1'b0;
      req_bus.last      = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = CSR_SIDE_KEY;
      csr_bus.data      = '0;
      rsp_bus.ready     = 1'b0;
      paused            = 1'b0;
      repeat (9) @(negedge clock);
      reset = 1'b0;

      write_csr(CSR_SIDE_KEY, '1);
      write_csr(CSR_SIDE_ENABLE, 64'd1);

      send_request(req_of(REQ_CHECK, 0, 0, '0));
      send_request(req_of(REQ_LOAD, 1, 0, '1));
      send_request(req_of(REQ_LOAD, BOARD_POINTS, 1, rand_word()));
      send_request(req_of(REQ_LOAD, BOARD_POINTS, 0, 64'h8000_0000_0000_0000));
      send_request(req_of(REQ_LOAD, 1, 1, rand_word()));
      send_request(req_of(REQ_LOAD, 0, 0, rand_word()));
      send_request(req_of(REQ_LOAD, POINT_MAX, 1, rand_word()));
      send_request(req_of(REQ_MOVE, 1, 0, '0));
      send_request(req_of(REQ_MOVE, BOARD_POINTS, 1, '0));
      send_request(req_of(REQ_MOVE, 0, 1, '1));
      send_request(req_of(REQ_MOVE, BOARD_POINTS + 1, 0, '0));
      send_request(req_of(REQ_TOGGLE, 0, 0, '0));
      send_request(req_of(REQ_RECORD, 0, 0, '0));
      send_request(req_of(REQ_SET, 0, 0, '1));
      send_request(req_of(REQ_RECORD, 0, 0, '0));
      send_request(req_of(REQ_CHECK, 0, 0, '1));
      send_request(req_of(REQ_CHECK, 0, 0, '0));
      send_request(req_of(REQ_REPLAY, 1, 0, '0, 1, 0));
      send_request(req_of(REQ_REPLAY, 1, 0, '0, 0, 1));
      send_request(req_of(REQ_REPLAY, BOARD_POINTS, 1, '0, 0, 1));
      send_request(req_of(REQ_REPLAY, 0, 0, '0, 1, 1));
      send_request(req_of(REQ_RESET, 0, 0, '0));
      send_request(req_of(REQ_CHECK, 0, 0, '0));
      send_request(req_of(REQ_REPLAY, POINT_MAX, 0, '0, 1, 1));
      send_request(req_of(REQ_SET, 0, 0, '0));
      drain();

      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_SIDE_KEY, rand_word());
               write_csr(CSR_SIDE_ENABLE, 64'd1);
            end
            1: begin
               write_csr(CSR_SIDE_KEY, '0);
               write_csr(CSR_SIDE_ENABLE, 64'd0);
            end
            2: begin
               write_csr(CSR_SIDE_KEY, '1);
               write_csr(CSR_SIDE_ENABLE, 64'd0);
            end
            3: begin
               write_csr(CSR_SIDE_KEY, rand_word());
               write_csr(CSR_SIDE_ENABLE, 64'd1);
            end
            default: begin
               write_csr(CSR_SIDE_KEY, 64'd1);
               write_csr(CSR_SIDE_ENABLE, 64'd1);
            end
         endcase
         quiet  = (phase == 2);
         target = sent_items + PHASE_ITEMS;
         while (sent_items < target) begin
            if (phase == 0 && !paused && sent_items + PHASE_ITEMS / 2 >= target) begin
               drain();
               paused = 1'b1;
            end
            if ($urandom_range(99) < 30) send_replay_run();
            else send_random_item();
         end
         drain();
      end

      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/zph_pkg.sv
rtl/zph_if.sv
rtl/zph_table_ram.sv
rtl/zobrist_position_hash_core.sv
rtl/zph_checker.sv
test/tb_zobrist_position_hash_core.sv
